### hdl/ssc_pkg.sv
// ============================================================================
// ssc_pkg: shared types and constants for the segment closest-point pipeline
// Fixed coordinate format, internal widths, payload structs and the epsilon
// rounding helper used at elaboration.
// ============================================================================
package ssc_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int FRAC_BITS_DEF = 16;

  // internal widths
  localparam int DW     = COORD_WIDTH + 1;   // coordinate differences
  localparam int SQ_W   = 2 * DW;            // product of two differences
  localparam int PW     = SQ_W + 2;          // dot products
  localparam int T_BITS = 30;                // line parameter fraction bits
  localparam int QW     = T_BITS + 1;        // line parameter, Q1.30
  localparam int PRW    = QW + 1 + DW;       // parameter times direction
  localparam int SW     = SQ_W + 2;          // sum of squared distances
  localparam int RW     = SW / 2;            // square root width

  localparam int WMUL_LAT  = 3;
  localparam int EPS_SCALE = 1000000;
  localparam int EPS_HALF  = 500000;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic        [COORD_WIDTH-1:0] dist_t;
  typedef logic signed [DW-1:0]          diff_t;
  typedef logic signed [SQ_W-1:0]        prod_t;
  typedef logic signed [PW-1:0]          dot_t;
  typedef logic signed [2*PW-1:0]        wprod_t;

  typedef struct packed {
    coord_t a_start_x;
    coord_t a_start_y;
    coord_t a_start_z;
    coord_t a_end_x;
    coord_t a_end_y;
    coord_t a_end_z;
    coord_t b_start_x;
    coord_t b_start_y;
    coord_t b_start_z;
    coord_t b_end_x;
    coord_t b_end_y;
    coord_t b_end_z;
  } req_t;

  typedef struct packed {
    dist_t  distance;
    coord_t near_a_x;
    coord_t near_a_y;
    coord_t near_a_z;
    coord_t near_b_x;
    coord_t near_b_y;
    coord_t near_b_z;
  } rsp_t;

  // segment geometry carried along the pipeline
  typedef struct packed {
    coord_t [2:0] as;
    coord_t [2:0] bs;
    diff_t  [2:0] u;
    diff_t  [2:0] v;
  } geo_t;

  typedef struct packed {
    dot_t a;
    dot_t b;
    dot_t c;
    dot_t d;
    dot_t e;
  } dots_t;

  typedef struct packed {
    coord_t [2:0] pa;
    coord_t [2:0] pb;
  } pts_t;

  // round(2^n / 10^6), long division at elaboration
  function automatic logic [127:0] eps_round(input int n);
    logic [127:0] num;
    logic [127:0] q;
    logic [31:0]  rem;
    num = (128'(1) << n) + 128'(EPS_HALF);
    q   = '0;
    rem = '0;
    for (int i = 127; i >= 0; i--) begin
      rem = {rem[30:0], num[i]};
      if (rem >= 32'(EPS_SCALE)) begin
        rem  = rem - 32'(EPS_SCALE);
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

endpackage

### hdl/segment_segment_closest_points.sv
// Throughput is one request per cycle, set by the fully pipelined divider
//   (one quotient bit a stage) and square root (one root bit).
// done marks each result for exactly one cycle; the receiver cannot stall.
// Reset (rst, synchronous) clears all valid bits; busy is high only during
//   reset. No clearing pass, no state between requests.
// ============================================================================
// segment_segment_closest_points: closest points between two 3-D segments
// Clamped closest-point method in exact fixed point: differences, dot
// products, wide cross terms, clamping, two parallel ratio dividers, closest
// point reconstruction and a rounding square root for the distance.
// ============================================================================
module segment_segment_closest_points import ssc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  // numerator width: holds D, the cross numerators and the epsilon constants
  localparam int NW = (2*PW + 2 > 4*FRAC_BITS + 2) ? 2*PW + 2 : 4*FRAC_BITS + 2;
  localparam logic signed [NW-1:0] EPS_W  = NW'(eps_round(4*FRAC_BITS));
  localparam logic signed [NW-1:0] EPS_N  = NW'(eps_round(2*FRAC_BITS));
  localparam logic signed [NW-1:0] UNIT_W = NW'(128'(1) << (4*FRAC_BITS));
  localparam logic signed [PRW-1:0] RND_HALF = PRW'(64'(1) << (T_BITS-1));
  localparam logic [QW-1:0] ONE_Q = QW'(1) << T_BITS;
  localparam int LAT = 3 + WMUL_LAT + 3 + (QW + 2) + 5 + (RW + 1);

  assign busy = rst;

  // ---------------------------------------------------------------------------
  // Stage 1: take the request, form direction and offset vectors
  // ---------------------------------------------------------------------------
  logic         v1;
  geo_t         geo1, geo1_next;
  diff_t [2:0]  w1, w1_next;

  always_comb begin
    geo1_next.as[0] = req.a_start_x;
    geo1_next.as[1] = req.a_start_y;
    geo1_next.as[2] = req.a_start_z;
    geo1_next.bs[0] = req.b_start_x;
    geo1_next.bs[1] = req.b_start_y;
    geo1_next.bs[2] = req.b_start_z;
    geo1_next.u[0]  = DW'(req.a_end_x) - DW'(req.a_start_x);
    geo1_next.u[1]  = DW'(req.a_end_y) - DW'(req.a_start_y);
    geo1_next.u[2]  = DW'(req.a_end_z) - DW'(req.a_start_z);
    geo1_next.v[0]  = DW'(req.b_end_x) - DW'(req.b_start_x);
    geo1_next.v[1]  = DW'(req.b_end_y) - DW'(req.b_start_y);
    geo1_next.v[2]  = DW'(req.b_end_z) - DW'(req.b_start_z);
    w1_next[0]      = DW'(req.a_start_x) - DW'(req.b_start_x);
    w1_next[1]      = DW'(req.a_start_y) - DW'(req.b_start_y);
    w1_next[2]      = DW'(req.a_start_z) - DW'(req.b_start_z);
  end

  always_ff @(posedge clk) begin
    geo1 <= geo1_next;
    w1   <= w1_next;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: the fifteen coordinate products
  // ---------------------------------------------------------------------------
  logic         v2;
  geo_t         geo2;
  prod_t [2:0]  puu, puv, pvv, puw, pvw;

  always_ff @(posedge clk) begin
    geo2 <= geo1;
    for (int k = 0; k < 3; k++) begin
      puu[k] <= SQ_W'(geo1.u[k]) * SQ_W'(geo1.u[k]);
      puv[k] <= SQ_W'(geo1.u[k]) * SQ_W'(geo1.v[k]);
      pvv[k] <= SQ_W'(geo1.v[k]) * SQ_W'(geo1.v[k]);
      puw[k] <= SQ_W'(geo1.u[k]) * SQ_W'(w1[k]);
      pvw[k] <= SQ_W'(geo1.v[k]) * SQ_W'(w1[k]);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot products a = u.u, b = u.v, c = v.v, d = u.w, e = v.w
  // ---------------------------------------------------------------------------
  logic   v3;
  geo_t   geo3;
  dots_t  dt3;

  always_ff @(posedge clk) begin
    geo3   <= geo2;
    dt3.a  <= PW'(puu[0]) + PW'(puu[1]) + PW'(puu[2]);
    dt3.b  <= PW'(puv[0]) + PW'(puv[1]) + PW'(puv[2]);
    dt3.c  <= PW'(pvv[0]) + PW'(pvv[1]) + PW'(pvv[2]);
    dt3.d  <= PW'(puw[0]) + PW'(puw[1]) + PW'(puw[2]);
    dt3.e  <= PW'(pvw[0]) + PW'(pvw[1]) + PW'(pvw[2]);
  end

  // ---------------------------------------------------------------------------
  // Stages 4-6: wide cross products, geometry held alongside
  // ---------------------------------------------------------------------------
  wprod_t p_ac, p_bb, p_be, p_cd, p_ae, p_bd;
  logic   mv   [WMUL_LAT];
  geo_t   mgeo [WMUL_LAT];
  dots_t  mdt  [WMUL_LAT];

  ssc_wmul #(.IW(PW)) u_mul_ac (.clk(clk), .x(dt3.a), .y(dt3.c), .p(p_ac));
  ssc_wmul #(.IW(PW)) u_mul_bb (.clk(clk), .x(dt3.b), .y(dt3.b), .p(p_bb));
  ssc_wmul #(.IW(PW)) u_mul_be (.clk(clk), .x(dt3.b), .y(dt3.e), .p(p_be));
  ssc_wmul #(.IW(PW)) u_mul_cd (.clk(clk), .x(dt3.c), .y(dt3.d), .p(p_cd));
  ssc_wmul #(.IW(PW)) u_mul_ae (.clk(clk), .x(dt3.a), .y(dt3.e), .p(p_ae));
  ssc_wmul #(.IW(PW)) u_mul_bd (.clk(clk), .x(dt3.b), .y(dt3.d), .p(p_bd));

  always_ff @(posedge clk) begin
    mgeo[0] <= geo3;
    mdt[0]  <= dt3;
    for (int i = 1; i < WMUL_LAT; i++) begin
      mgeo[i] <= mgeo[i-1];
      mdt[i]  <= mdt[i-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: determinant and unclamped numerators
  // ---------------------------------------------------------------------------
  logic                 v7;
  geo_t                 geo7;
  dots_t                dt7;
  logic signed [NW-1:0] dd7, sn7, tn7;

  always_ff @(posedge clk) begin
    geo7 <= mgeo[WMUL_LAT-1];
    dt7  <= mdt[WMUL_LAT-1];
    dd7  <= NW'(p_ac) - NW'(p_bb);
    sn7  <= NW'(p_be) - NW'(p_cd);
    tn7  <= NW'(p_ae) - NW'(p_bd);
  end

  // ---------------------------------------------------------------------------
  // Stage 8: parallel test and clamp of s to the ends of segment A
  // ---------------------------------------------------------------------------
  logic                 v8;
  geo_t                 geo8;
  dot_t                 a8, b8, d8;
  logic signed [NW-1:0] sn8, sd8, tn8, td8;
  logic                 tw8;
  logic signed [NW-1:0] sn8_next, sd8_next, tn8_next, td8_next;
  logic                 tw8_next, par8, sgt8;

  always_comb begin
    par8     = dd7 < EPS_W;
    sgt8     = sn7 > dd7;
    sn8_next = sn7;
    sd8_next = dd7;
    tn8_next = tn7;
    td8_next = dd7;
    tw8_next = 1'b1;
    if (par8) begin
      // nearly parallel: pin s to the start of A
      sn8_next = '0;
      sd8_next = UNIT_W;
      tn8_next = NW'(dt7.e);
      td8_next = NW'(dt7.c);
      tw8_next = 1'b0;
    end else if (sn7[NW-1]) begin
      sn8_next = '0;
      tn8_next = NW'(dt7.e);
      td8_next = NW'(dt7.c);
      tw8_next = 1'b0;
    end else if (sgt8) begin
      sn8_next = dd7;
      tn8_next = NW'(dt7.e) + NW'(dt7.b);
      td8_next = NW'(dt7.c);
      tw8_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    geo8 <= geo7;
    a8   <= dt7.a;
    b8   <= dt7.b;
    d8   <= dt7.d;
    sn8  <= sn8_next;
    sd8  <= sd8_next;
    tn8  <= tn8_next;
    td8  <= td8_next;
    tw8  <= tw8_next;
  end

  // ---------------------------------------------------------------------------
  // Stage 9: clamp t to the ends of segment B, recompute s where needed
  // ---------------------------------------------------------------------------
  logic                 v9;
  geo_t                 geo9;
  logic signed [NW-1:0] sn9, sd9, tn9, td9;
  logic                 sw9, tw9;
  logic signed [NW-1:0] sn9_next, sd9_next, tn9_next, nd_lo, nd_hi, nd;
  logic                 sw9_next, tneg, tgt, lo_gt, hi_gt, nneg, ngt;

  always_comb begin
    tneg     = tn8[NW-1];
    tgt      = tn8 > td8;
    nd_lo    = -NW'(d8);
    nd_hi    = NW'(b8) - NW'(d8);
    lo_gt    = nd_lo > NW'(a8);
    hi_gt    = nd_hi > NW'(a8);
    nd       = tneg ? nd_lo : nd_hi;
    nneg     = nd[NW-1];
    ngt      = tneg ? lo_gt : hi_gt;
    sn9_next = sn8;
    sd9_next = sd8;
    sw9_next = 1'b1;
    tn9_next = tn8;
    if (tneg || tgt) begin
      tn9_next = tneg ? '0 : td8;
      if (nneg) begin
        sn9_next = '0;
      end else if (ngt) begin
        sn9_next = sd8;
      end else begin
        sn9_next = nd;
        sd9_next = NW'(a8);
        sw9_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    geo9 <= geo8;
    sn9  <= sn9_next;
    sd9  <= sd9_next;
    sw9  <= sw9_next;
    tn9  <= tn9_next;
    td9  <= td8;
    tw9  <= tw8;
  end

  // ---------------------------------------------------------------------------
  // Ratio dividers: sc and tc as Q1.30
  // ---------------------------------------------------------------------------
  logic          rv;
  logic [QW-1:0] sc, tc;
  geo_t          rgeo;

  ssc_ratio #(.NW(NW)) u_ratio (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v9),
    .s_num    (sn9),
    .s_den    (sd9),
    .s_eps    (sw9 ? EPS_W : EPS_N),
    .t_num    (tn9),
    .t_den    (td9),
    .t_eps    (tw9 ? EPS_W : EPS_N),
    .side_in  (geo9),
    .out_valid(rv),
    .sc       (sc),
    .tc       (tc),
    .side_out (rgeo)
  );

  // ---------------------------------------------------------------------------
  // Points: param * direction, round half up, add start point
  // ---------------------------------------------------------------------------
  logic                  v10, v11, v12, v13, v14;
  geo_t                  geo10;
  logic signed [PRW-1:0] pra [3];
  logic signed [PRW-1:0] prb [3];
  logic signed [PRW-1:0] sha [3];
  logic signed [PRW-1:0] shb [3];
  pts_t                  pts11, pts11_next, pts12, pts13, pts14;
  logic signed [COORD_WIDTH:0] df12 [3];
  prod_t                 sq13 [3];
  logic [SW-1:0]         sum14;

  always_ff @(posedge clk) begin
    geo10 <= rgeo;
    for (int k = 0; k < 3; k++) begin
      pra[k] <= PRW'($signed({1'b0, sc})) * PRW'(rgeo.u[k]);
      prb[k] <= PRW'($signed({1'b0, tc})) * PRW'(rgeo.v[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sha[k] = (pra[k] + RND_HALF) >>> T_BITS;
      shb[k] = (prb[k] + RND_HALF) >>> T_BITS;
      pts11_next.pa[k] = COORD_WIDTH'(PRW'(geo10.as[k]) + sha[k]);
      pts11_next.pb[k] = COORD_WIDTH'(PRW'(geo10.bs[k]) + shb[k]);
    end
  end

  always_ff @(posedge clk) begin
    pts11 <= pts11_next;
    pts12 <= pts11;
    pts13 <= pts12;
    pts14 <= pts13;
    for (int k = 0; k < 3; k++) begin
      df12[k] <= (COORD_WIDTH+1)'(pts11.pa[k]) - (COORD_WIDTH+1)'(pts11.pb[k]);
      sq13[k] <= SQ_W'(df12[k]) * SQ_W'(df12[k]);
    end
    sum14 <= SW'($unsigned(sq13[0])) + SW'($unsigned(sq13[1])) +
             SW'($unsigned(sq13[2]));
  end

  // ---------------------------------------------------------------------------
  // Distance: rounding square root, saturated; drives the result ports
  // ---------------------------------------------------------------------------
  dist_t seg_dist;
  pts_t  pts_out;

  ssc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (v14),
    .radicand (sum14),
    .pts_in   (pts14),
    .out_valid(done),
    .distance (seg_dist),
    .pts_out  (pts_out)
  );

  always_comb begin
    rsp.distance = seg_dist;
    rsp.near_a_x = pts_out.pa[0];
    rsp.near_a_y = pts_out.pa[1];
    rsp.near_a_z = pts_out.pa[2];
    rsp.near_b_x = pts_out.pb[0];
    rsp.near_b_y = pts_out.pb[1];
    rsp.near_b_z = pts_out.pb[2];
  end

  // ---------------------------------------------------------------------------
  // Valid bits: advance with the data, cleared by reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      v3  <= 1'b0;
      for (int i = 0; i < WMUL_LAT; i++) mv[i] <= 1'b0;
      v7  <= 1'b0;
      v8  <= 1'b0;
      v9  <= 1'b0;
      v10 <= 1'b0;
      v11 <= 1'b0;
      v12 <= 1'b0;
      v13 <= 1'b0;
      v14 <= 1'b0;
    end else begin
      v1    <= start && !busy;
      v2    <= v1;
      v3    <= v2;
      mv[0] <= v3;
      for (int i = 1; i < WMUL_LAT; i++) mv[i] <= mv[i-1];
      v7    <= mv[WMUL_LAT-1];
      v8    <= v7;
      v9    <= v8;
      v10   <= rv;
      v11   <= v10;
      v12   <= v11;
      v13   <= v12;
      v14   <= v13;
    end
  end

`ifndef SYNTHESIS
  a_latency_fwd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request did not produce a result at the expected latency");

  a_latency_bwd: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result strobed without a matching request");

  a_zero_dist: assert property (@(posedge clk) disable iff (rst)
    done |-> ((rsp.distance == '0) == (pts_out.pa == pts_out.pb)))
    else $error("distance zero does not match coincident closest points");

  a_param_range: assert property (@(posedge clk) disable iff (rst)
    rv |-> (sc <= ONE_Q) && (tc <= ONE_Q))
    else $error("segment parameter outside [0,1]");
`endif

endmodule

### hdl/ssc_wmul.sv
// ============================================================================
// ssc_wmul: pipelined signed wide multiplier
// Splits magnitudes into halves, forms four partial products, then sums them
// and restores the sign. Three register stages.
// ============================================================================
module ssc_wmul import ssc_pkg::*; #(
  parameter int IW = PW
) (
  input  logic                   clk,
  input  logic signed [IW-1:0]   x,
  input  logic signed [IW-1:0]   y,
  output logic signed [2*IW-1:0] p
);

  localparam int H = (IW + 1) / 2;

  logic [2*H-1:0] xm, ym;
  logic           neg1, neg2;
  logic [2*H-1:0] pll, plh, phl, phh;
  logic [4*H-1:0] full;

  // stage 1: magnitudes and sign
  always_ff @(posedge clk) begin
    xm   <= (2*H)'(x[IW-1] ? IW'(-x) : IW'(x));
    ym   <= (2*H)'(y[IW-1] ? IW'(-y) : IW'(y));
    neg1 <= x[IW-1] ^ y[IW-1];
  end

  // stage 2: partial products
  always_ff @(posedge clk) begin
    pll  <= (2*H)'(xm[H-1:0])   * (2*H)'(ym[H-1:0]);
    plh  <= (2*H)'(xm[H-1:0])   * (2*H)'(ym[2*H-1:H]);
    phl  <= (2*H)'(xm[2*H-1:H]) * (2*H)'(ym[H-1:0]);
    phh  <= (2*H)'(xm[2*H-1:H]) * (2*H)'(ym[2*H-1:H]);
    neg2 <= neg1;
  end

  // stage 3: combine and restore sign
  always_comb begin
    full = {phh, pll} + (((4*H)'(plh) + (4*H)'(phl)) << H);
  end

  always_ff @(posedge clk) begin
    p <= (2*IW)'(neg2 ? -full : full);
  end

endmodule

### hdl/ssc_ratio.sv
// ============================================================================
// ssc_ratio: two-lane pipelined clamped ratio
// Forms num/den as unsigned Q1.30 for the s and t parameters, one restoring
// division step per stage, with epsilon and clamp checks up front.
// ============================================================================
module ssc_ratio import ssc_pkg::*; #(
  parameter int NW = 2 * PW + 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic signed [NW-1:0] s_num,
  input  logic signed [NW-1:0] s_den,
  input  logic signed [NW-1:0] s_eps,
  input  logic signed [NW-1:0] t_num,
  input  logic signed [NW-1:0] t_den,
  input  logic signed [NW-1:0] t_eps,
  input  geo_t                 side_in,
  output logic                 out_valid,
  output logic [QW-1:0]        sc,
  output logic [QW-1:0]        tc,
  output geo_t                 side_out
);

  localparam logic [QW-1:0] ONE_Q = QW'(1) << T_BITS;

  logic signed [NW-1:0] num_i [2];
  logic signed [NW-1:0] den_i [2];
  logic signed [NW-1:0] eps_i [2];
  logic                 zf_i  [2];
  logic                 of_i  [2];

  logic [NW-1:0] rem [2][QW+1];
  logic [NW-1:0] den [2][QW+1];
  logic [QW-1:0] q   [2][QW+1];
  logic          zf  [2][QW+1];
  logic          of  [2][QW+1];
  logic          vld [QW+1];
  geo_t          gq  [QW+1];

  logic [NW-1:0] r2       [2][QW];
  logic          ge       [2][QW];
  logic [NW-1:0] rem_next [2][QW];
  logic [QW:0]   qp       [2];
  logic [QW-1:0] res      [2];

  always_comb begin
    num_i[0] = s_num;
    den_i[0] = s_den;
    eps_i[0] = s_eps;
    num_i[1] = t_num;
    den_i[1] = t_den;
    eps_i[1] = t_eps;
    for (int l = 0; l < 2; l++) begin
      zf_i[l] = num_i[l][NW-1] || (num_i[l] == '0) || (num_i[l] < eps_i[l]) ||
                den_i[l][NW-1] || (den_i[l] == '0);
      of_i[l] = num_i[l] >= den_i[l];
    end
  end

  // one quotient bit per stage
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      for (int j = 0; j < QW; j++) begin
        r2[l][j]       = {rem[l][j][NW-2:0], 1'b0};
        ge[l][j]       = r2[l][j] >= den[l][j];
        rem_next[l][j] = ge[l][j] ? r2[l][j] - den[l][j] : r2[l][j];
      end
    end
  end

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qp[l] = (QW+1)'(q[l][QW]) + (QW+1)'(1);
      if (zf[l][QW]) begin
        res[l] = '0;
      end else if (of[l][QW]) begin
        res[l] = ONE_Q;
      end else begin
        res[l] = qp[l][QW:1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= QW; j++) vld[j] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vld[0] <= in_valid;
      for (int j = 0; j < QW; j++) vld[j+1] <= vld[j];
      out_valid <= vld[QW];
    end
  end

  always_ff @(posedge clk) begin
    gq[0] <= side_in;
    for (int l = 0; l < 2; l++) begin
      zf[l][0]  <= zf_i[l];
      of[l][0]  <= of_i[l];
      rem[l][0] <= (zf_i[l] || of_i[l]) ? '0 : num_i[l];
      den[l][0] <= den_i[l];
      q[l][0]   <= '0;
    end
    for (int j = 0; j < QW; j++) begin
      gq[j+1] <= gq[j];
      for (int l = 0; l < 2; l++) begin
        rem[l][j+1] <= rem_next[l][j];
        den[l][j+1] <= den[l][j];
        q[l][j+1]   <= {q[l][j][QW-2:0], ge[l][j]};
        zf[l][j+1]  <= zf[l][j];
        of[l][j+1]  <= of[l][j];
      end
    end
    sc       <= res[0];
    tc       <= res[1];
    side_out <= gq[QW];
  end

endmodule

### hdl/ssc_sqrt.sv
// ============================================================================
// ssc_sqrt: pipelined rounding square root with saturation
// One root bit per stage, then round to nearest and clamp to the distance
// range in a final output register.
// ============================================================================
module ssc_sqrt import ssc_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [SW-1:0] radicand,
  input  pts_t          pts_in,
  output logic          out_valid,
  output dist_t         distance,
  output pts_t          pts_out
);

  localparam int RB = RW + 2;
  localparam logic [RW:0] CMAX = (RW+1)'({COORD_WIDTH{1'b1}});

  logic [SW-1:0] rad [RW];
  logic [RB-1:0] rm  [RW];
  logic [RW-1:0] rt  [RW];
  logic          vl  [RW];
  pts_t          pp  [RW];

  logic [SW-1:0] cr_rad [RW];
  logic [RB-1:0] cr_rm  [RW];
  logic [RW-1:0] cr_rt  [RW];
  logic [RB-1:0] rem2   [RW];
  logic [RB-1:0] trial  [RW];
  logic          ge     [RW];

  logic          up;
  logic [RW:0]   rnd;

  always_comb begin
    cr_rad[0] = radicand;
    cr_rm[0]  = '0;
    cr_rt[0]  = '0;
    for (int j = 1; j < RW; j++) begin
      cr_rad[j] = rad[j-1];
      cr_rm[j]  = rm[j-1];
      cr_rt[j]  = rt[j-1];
    end
    for (int j = 0; j < RW; j++) begin
      rem2[j]  = {cr_rm[j][RB-3:0], cr_rad[j][SW-1:SW-2]};
      trial[j] = {cr_rt[j], 2'b01};
      ge[j]    = rem2[j] >= trial[j];
    end
  end

  always_comb begin
    up  = rm[RW-1] > RB'(rt[RW-1]);
    rnd = (RW+1)'(rt[RW-1]) + (RW+1)'(up);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < RW; j++) vl[j] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      vl[0] <= in_valid;
      for (int j = 1; j < RW; j++) vl[j] <= vl[j-1];
      out_valid <= vl[RW-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < RW; j++) begin
      rad[j] <= {cr_rad[j][SW-3:0], 2'b00};
      rm[j]  <= ge[j] ? rem2[j] - trial[j] : rem2[j];
      rt[j]  <= {cr_rt[j][RW-2:0], ge[j]};
    end
    pp[0] <= pts_in;
    for (int j = 1; j < RW; j++) pp[j] <= pp[j-1];
    distance <= (rnd > CMAX) ? '1 : rnd[COORD_WIDTH-1:0];
    pts_out  <= pp[RW-1];
  end

endmodule
